>>> design/dstq_pkg.sv
package dstq_pkg;

  // Default queue depth and the cap on expiries reported by one tick.
  localparam int TIMER_SLOTS_DEF = 64;
  localparam int MAX_RESULTS     = 64;

  // Field widths.
  localparam int DL_W     = 64;
  localparam int DELAY_W  = 40;
  localparam int TAG_W    = 32;
  localparam int RID_W    = 7;
  localparam int OUT_ID_W = 7;
  localparam int LOAD_W   = 32;
  localparam int WIN_W    = 24;
  localparam int TPU_W    = 8;

  // Stream payload widths; the tdata widths are rounded up to whole bytes.
  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 1;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_US_RST    = 24'd100000;
  localparam logic [TPU_W-1:0] TICKS_PER_US_RST = 8'd66;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_US    = 1'd0,
    CFG_TICKS_PER_US = 1'd1
  } cfg_idx_t;

endpackage

>>> design/dstq_ram.sv
module dstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/deadline_sorted_timer_queue.sv
// Deadline-sorted timer queue with recycled ids and fine-timer arming.
//
// Requests arrive on the s_axis channel: tuser carries the operation (register,
// remove, tick) and tdata carries now, delay, tag and remove_id. Each request
// produces one or more results on the m_axis channel; tlast marks the final
// result of a request. The cfg channel writes window_us (index 0) and
// ticks_per_us (index 1) and is always ready.
//
// Flow: a request is taken only while the sequencer is idle. A register
// request pops a free id and walks the deadline ring from the tail, moving each
// timer with a later deadline back one slot; a remove scans from the head to the
// removed timer and shifts the timers behind it forward; a tick scans the head
// for expired timers, then gives one result per cycle while the receiver is
// ready. The walk over the deadline ring handles one entry per cycle.
//
// Reset clears the queue and restores the register defaults at once; there is
// no clearing pass. When the receiver stalls, results wait in the output
// register and the sequencer holds; once the last result of a request sits in
// the output register the next request may be accepted.
module deadline_sorted_timer_queue #(
  parameter int TIMER_SLOTS = dstq_pkg::TIMER_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata, from bit 0: now[63:0], delay[39:0], tag[31:0], remove_id[6:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dstq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // s_axis_tuser, from bit 0: op[1:0]
  input  logic [dstq_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // m_axis_tdata, from bit 0: timer_id[6:0], user_tag[31:0], fine_enable,
  // fine_load[31:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dstq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  // m_axis_tuser, from bit 0: status[1:0], expired
  output logic [dstq_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dstq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dstq_pkg::WIN_W-1:0]          cfg_data
);

  import dstq_pkg::*;

  localparam int N   = TIMER_SLOTS;
  localparam int AW  = $clog2(N);
  localparam int CW  = $clog2(N + 1);
  localparam int IDW = CW;
  localparam int IDX = (IDW > OUT_ID_W) ? IDW : OUT_ID_W;
  localparam int RW  = DL_W + TAG_W + IDW;

  localparam logic [CW-1:0] N_C = CW'(N);
  localparam logic [AW:0]   N_A = (AW + 1)'(N);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_START     = 16'h0002,
    S_REG_POP   = 16'h0004,
    S_REG_WALK  = 16'h0008,
    S_REG_PLACE = 16'h0010,
    S_RM_SCAN   = 16'h0020,
    S_RM_SHIFT  = 16'h0040,
    S_RM_PUSH   = 16'h0080,
    S_TK_SCAN   = 16'h0100,
    S_TK_DONE   = 16'h0200,
    S_FIN_RD    = 16'h0400,
    S_FIN_CMP   = 16'h0800,
    S_FIN_MUL   = 16'h1000,
    S_RES_OUT   = 16'h2000,
    S_EM_RD     = 16'h4000,
    S_EM_OUT    = 16'h8000
  } state_t;

  // Ring offset addition modulo the queue depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= N_A) begin
      s = s - N_A;
    end
    return s[AW-1:0];
  endfunction

  // Request fields.
  logic [1:0]         in_op;
  logic [DL_W-1:0]    in_now;
  logic [DELAY_W-1:0] in_delay;
  logic [TAG_W-1:0]   in_tag;
  logic [RID_W-1:0]   in_rid;

  assign in_op    = s_axis_tuser[1:0];
  assign in_now   = s_axis_tdata[63:0];
  assign in_delay = s_axis_tdata[103:64];
  assign in_tag   = s_axis_tdata[135:104];
  assign in_rid   = s_axis_tdata[142:136];

  // Configuration.
  logic [WIN_W-1:0] window_us;
  logic [TPU_W-1:0] ticks_per_us;

  // Sequencer state and queue bookkeeping.
  state_t          state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [AW-1:0]   exp_head, exp_head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   j, j_next;
  logic [CW-1:0]   k, k_next;
  logic [IDW-1:0]  new_id, new_id_next;
  logic [IDW-1:0]  res_id, res_id_next;
  status_t         res_status, res_status_next;

  // Latched request.
  op_t              op_r;
  logic [DL_W-1:0]  now_r;
  logic [DL_W-1:0]  nowwin_r;
  logic [DL_W-1:0]  dl_r;
  logic [TAG_W-1:0] tag_r;
  logic [RID_W-1:0] rid_r;

  // Fine-timer arithmetic.
  logic                     en_r;
  logic [LOAD_W-1:0]        diff_r;
  logic [LOAD_W-1:0]        load_r;
  logic [LOAD_W+TPU_W-1:0]  prod;

  // Deadline ring: {id, tag, deadline} per slot, kept sorted from head.
  logic           ring_re, ring_we;
  logic [AW-1:0]  ring_raddr, ring_waddr, ring_base;
  logic [CW-1:0]  rl;
  logic [RW-1:0]  ring_wdata, ring_q;
  logic [DL_W-1:0]  q_dl;
  logic [TAG_W-1:0] q_tag;
  logic [IDW-1:0]   q_id;

  // Free id stack; an entry never written reads as depth minus its address.
  logic           stk_re, stk_we;
  logic [AW-1:0]  stk_raddr, stk_waddr;
  logic [IDW-1:0] stk_wdata, stk_q;
  logic [N-1:0]   stk_vld;
  logic [AW-1:0]  stk_rd_addr_r;
  logic           stk_rd_vld_r;
  logic [IDW-1:0] pop_id;
  logic [CW-1:0]  stk_pop_full, stk_push_full, stk_ret_full;

  // Output register.
  logic              out_free, out_load;
  status_t           out_status;
  logic [IDW-1:0]    out_id;
  logic [IDX-1:0]    out_id_ext;
  logic [TAG_W-1:0]  out_tag;
  logic              out_exp, out_last;
  logic              m_valid;
  status_t           m_status;
  logic              m_expired, m_last, m_en;
  logic [OUT_ID_W-1:0] m_id;
  logic [TAG_W-1:0]  m_tag;
  logic [LOAD_W-1:0] m_load;

  // Loop helpers.
  logic [CW:0] j_ext, cnt_ext, j_p1, j_p2, k_ext;
  logic        id_match, rid_ok, accept;

  assign q_dl  = ring_q[DL_W-1:0];
  assign q_tag = ring_q[DL_W+TAG_W-1:DL_W];
  assign q_id  = ring_q[RW-1:DL_W+TAG_W];

  assign j_ext   = {1'b0, j};
  assign cnt_ext = {1'b0, count};
  assign k_ext   = {1'b0, k};
  assign j_p1    = j_ext + (CW + 1)'(1);
  assign j_p2    = j_ext + (CW + 1)'(2);

  assign id_match = (IDX'(q_id) == IDX'(rid_r));
  assign rid_ok   = (rid_r != '0) && (int'(rid_r) <= N);

  assign stk_pop_full  = N_C - CW'(1) - count;
  assign stk_push_full = N_C - count;
  assign stk_ret_full  = N_C - CW'(1) - count - j;
  assign pop_id = stk_rd_vld_r ? stk_q : (N_C - CW'(stk_rd_addr_r));

  assign out_free = !m_valid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign prod = {{TPU_W{1'b0}}, diff_r} * {{LOAD_W{1'b0}}, ticks_per_us};

  always_comb begin
    state_next      = state;
    head_next       = head;
    exp_head_next   = exp_head;
    count_next      = count;
    j_next          = j;
    k_next          = k;
    new_id_next     = new_id;
    res_id_next     = res_id;
    res_status_next = res_status;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    ring_base  = head;
    rl         = '0;
    ring_wdata = ring_q;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = q_id;
    out_load   = 1'b0;
    out_status = ST_OK;
    out_id     = '0;
    out_tag    = '0;
    out_exp    = 1'b0;
    out_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_START;
        end
      end

      S_START: begin
        res_status_next = ST_OK;
        res_id_next     = '0;
        k_next          = '0;
        j_next          = '0;
        unique case (op_r)
          OP_REGISTER: begin
            if (count == N_C) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN_RD;
            end else begin
              stk_re     = 1'b1;
              stk_raddr  = stk_pop_full[AW-1:0];
              j_next     = count;
              state_next = S_REG_POP;
            end
          end
          OP_REMOVE: begin
            if (!rid_ok || count == '0) begin
              res_status_next = ST_BAD;
              state_next      = S_FIN_RD;
            end else begin
              ring_re    = 1'b1;
              state_next = S_RM_SCAN;
            end
          end
          OP_TICK: begin
            if (count == '0) begin
              state_next = S_FIN_RD;
            end else begin
              ring_re    = 1'b1;
              state_next = S_TK_SCAN;
            end
          end
          default: begin
            state_next = S_FIN_RD;
          end
        endcase
      end

      S_REG_POP: begin
        new_id_next = pop_id;
        res_id_next = pop_id;
        if (j == '0) begin
          state_next = S_REG_PLACE;
        end else begin
          ring_re    = 1'b1;
          rl         = j - CW'(1);
          state_next = S_REG_WALK;
        end
      end

      // The entry ahead moves back one slot while its deadline is later.
      S_REG_WALK: begin
        if (q_dl > dl_r) begin
          ring_we = 1'b1;
          j_next  = j - CW'(1);
          if (j == CW'(1)) begin
            state_next = S_REG_PLACE;
          end else begin
            ring_re = 1'b1;
            rl      = j - CW'(2);
          end
        end else begin
          state_next = S_REG_PLACE;
        end
      end

      S_REG_PLACE: begin
        ring_we    = 1'b1;
        ring_wdata = {new_id, tag_r, dl_r};
        count_next = count + CW'(1);
        state_next = S_FIN_RD;
      end

      S_RM_SCAN: begin
        if (j_p1 < cnt_ext) begin
          ring_re = 1'b1;
          rl      = j_p1[CW-1:0];
        end
        if (id_match) begin
          state_next = (j_p1 < cnt_ext) ? S_RM_SHIFT : S_RM_PUSH;
        end else if (j_p1 < cnt_ext) begin
          j_next = j_p1[CW-1:0];
        end else begin
          res_status_next = ST_BAD;
          state_next      = S_FIN_RD;
        end
      end

      S_RM_SHIFT: begin
        ring_we = 1'b1;
        j_next  = j_p1[CW-1:0];
        if (j_p2 < cnt_ext) begin
          ring_re = 1'b1;
          rl      = j_p2[CW-1:0];
        end else begin
          state_next = S_RM_PUSH;
        end
      end

      // The cancelled id becomes the next one handed out.
      S_RM_PUSH: begin
        stk_we     = 1'b1;
        stk_waddr  = stk_push_full[AW-1:0];
        stk_wdata  = IDW'(rid_r);
        count_next = count - CW'(1);
        state_next = S_FIN_RD;
      end

      S_TK_SCAN: begin
        if (q_dl <= now_r) begin
          if (j_p1 < cnt_ext && int'(j_p1) < MAX_RESULTS) begin
            ring_re = 1'b1;
            rl      = j_p1[CW-1:0];
            j_next  = j_p1[CW-1:0];
          end else begin
            k_next     = j_p1[CW-1:0];
            state_next = S_TK_DONE;
          end
        end else begin
          k_next     = j;
          state_next = S_TK_DONE;
        end
      end

      // Expired entries stay in the ring behind the new head until reported.
      S_TK_DONE: begin
        exp_head_next = head;
        head_next     = wrap_add(head, k[AW-1:0]);
        count_next    = count - k;
        j_next        = '0;
        state_next    = S_FIN_RD;
      end

      S_FIN_RD: begin
        ring_re    = 1'b1;
        state_next = S_FIN_CMP;
      end

      S_FIN_CMP: begin
        state_next = S_FIN_MUL;
      end

      S_FIN_MUL: begin
        if (k != '0) begin
          state_next = S_EM_RD;
        end else begin
          state_next = S_RES_OUT;
        end
      end

      S_RES_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = res_status;
          out_id     = res_id;
          state_next = S_IDLE;
        end
      end

      S_EM_RD: begin
        ring_re    = 1'b1;
        ring_base  = exp_head;
        rl         = j;
        state_next = S_EM_OUT;
      end

      // One expiry per cycle while the output register is free; its id returns to the free stack in order.
      S_EM_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_id     = q_id;
          out_tag    = q_tag;
          out_exp    = 1'b1;
          out_last   = (j_p1 == k_ext);
          stk_we     = 1'b1;
          stk_waddr  = stk_ret_full[AW-1:0];
          stk_wdata  = q_id;
          if (j_p1 == k_ext) begin
            state_next = S_IDLE;
          end else begin
            ring_re   = 1'b1;
            ring_base = exp_head;
            rl        = j_p1[CW-1:0];
            j_next    = j_p1[CW-1:0];
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    ring_raddr = wrap_add(ring_base, rl[AW-1:0]);
    ring_waddr = wrap_add(head, j[AW-1:0]);
  end

  assign out_id_ext = IDX'(out_id);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      k            <= '0;
      stk_vld      <= '0;
      m_valid      <= 1'b0;
      window_us    <= WINDOW_US_RST;
      ticks_per_us <= TICKS_PER_US_RST;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      k     <= k_next;
      if (stk_we) begin
        stk_vld[stk_waddr] <= 1'b1;
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_US:    window_us    <= cfg_data;
          CFG_TICKS_PER_US: ticks_per_us <= cfg_data[TPU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    exp_head   <= exp_head_next;
    j          <= j_next;
    new_id     <= new_id_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    if (accept) begin
      op_r     <= op_t'(in_op);
      now_r    <= in_now;
      dl_r     <= in_now + DL_W'(in_delay);
      tag_r    <= in_tag;
      rid_r    <= in_rid;
      nowwin_r <= in_now + DL_W'(window_us);
    end
    if (state == S_FIN_CMP) begin
      en_r   <= (count != '0) && (q_dl <= nowwin_r);
      diff_r <= q_dl[LOAD_W-1:0] - now_r[LOAD_W-1:0];
    end
    if (state == S_FIN_MUL) begin
      load_r <= en_r ? prod[LOAD_W-1:0] : '0;
    end
    if (stk_re) begin
      stk_rd_addr_r <= stk_raddr;
      stk_rd_vld_r  <= stk_vld[stk_raddr];
    end
    if (out_load) begin
      m_status  <= out_status;
      m_id      <= out_id_ext[OUT_ID_W-1:0];
      m_tag     <= out_tag;
      m_expired <= out_exp;
      m_last    <= out_last;
      m_en      <= en_r;
      m_load    <= load_r;
    end
  end

  dstq_ram #(
    .WIDTH (RW),
    .DEPTH (N)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  dstq_ram #(
    .WIDTH (IDW),
    .DEPTH (N)
  ) u_free_ids (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_load, m_en, m_tag, m_id};
  assign m_axis_tlast  = m_last;
  assign m_axis_tuser  = {m_expired, m_status};

endmodule
